/* rtl/core/fqvd_pkg.sv */
// Shared request, status and field-width definitions for the deduplicating FIFO.
`default_nettype none

package fqvd_pkg;

    localparam int ReqW    = 2;
    localparam int StatW   = 2;
    localparam int ValW    = 32;
    localparam int MatchW  = 5;
    localparam int RemW    = 4;
    localparam int OccW    = 5;

    typedef logic [ReqW-1:0]  t_req;
    typedef logic [StatW-1:0] t_status;

    localparam t_req REQ_PUSH   = 2'd0;
    localparam t_req REQ_POP    = 2'd1;
    localparam t_req REQ_DEDUP  = 2'd2;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

endpackage

`default_nettype wire

/* rtl/core/fqvd_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module fqvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/fifo_queue_with_value_dedup_top.sv */
// Top level of the bounded FIFO with push, pop and in-place repeat removal.
`default_nettype none

// The queue holds up to DEPTH signed 32-bit values in a circular buffer kept in a
// single simple dual-port RAM, with a head pointer and a fill count. Each accepted
// transaction gives exactly one result transaction. A push passes the states
// START and FIN, a pop START, POPW and FIN, as the head entry comes through
// the RAM's registered read port. Repeat removal walks the queue one entry per
// cycle through that same read port, compacting the kept entries through the
// write port behind it. The input is stalled for the whole of a transaction and
// while a finished result waits for the output register to free up. No clearing
// pass is needed after reset; only state, fill, head and output valid are reset.
module fifo_queue_with_value_dedup_top
    import fqvd_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [ReqW-1:0]   i_req_type,
    input  wire logic signed [ValW-1:0] i_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [StatW-1:0]       o_status,
    output logic signed [ValW-1:0] o_popped_value,
    output logic [MatchW-1:0]      o_match_count,
    output logic [RemW-1:0]        o_removed_count,
    output logic [OccW-1:0]        o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_POPW  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // Physical slot of a logical offset from the head, wrapping at DEPTH.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_fill, n_fill;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_wr_cnt, n_wr_cnt;
    logic [CW-1:0]        r_match, n_match;
    t_req                 r_req;
    logic [ValW-1:0]      r_val;
    t_status              r_status, n_status;
    logic [ValW-1:0]      r_popped, n_popped;
    logic                 r_out_valid;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ValW-1:0]      ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [ValW-1:0]      ram_rdata;

    logic                 in_acc;
    logic                 out_free;
    logic                 hit;
    logic                 keep;
    logic                 last;
    logic [31:0]          match_ext;
    logic [31:0]          rem_ext;
    logic [31:0]          occ_ext;

    fqvd_ram #(
        .WIDTH (ValW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign hit  = (ram_rdata == r_val);
    assign keep = !hit || (r_match == '0);
    assign last = (CW'(r_idx) == r_fill - CW'(1));

    // The read runs one entry ahead of the entry being judged, so the write,
    // which never passes the read, cannot disturb data not yet fetched.
    assign ram_raddr = (r_state == S_SCAN) ? slot(r_head, CW'(r_idx) + CW'(1)) : r_head;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_head    = r_head;
        n_idx     = r_idx;
        n_wr_cnt  = r_wr_cnt;
        n_match   = r_match;
        n_status  = r_status;
        n_popped  = r_popped;
        ram_we    = 1'b0;
        ram_waddr = slot(r_head, r_wr_cnt);
        ram_wdata = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state  = S_START;
                    n_idx    = '0;
                    n_wr_cnt = '0;
                    n_match  = '0;
                    n_status = STAT_OK;
                    n_popped = '0;
                end
            end
            S_START: begin
                n_state = S_FIN;
                unique case (r_req)
                    REQ_PUSH: begin
                        if (r_fill == CW'(DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = slot(r_head, r_fill);
                            ram_wdata = r_val;
                            n_fill    = r_fill + CW'(1);
                        end
                    end
                    REQ_POP: begin
                        if (r_fill == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_state = S_POPW;
                        end
                    end
                    REQ_DEDUP: begin
                        if (r_fill == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_POPW: begin
                n_popped = ram_rdata;
                n_head   = slot(r_head, CW'(1));
                n_fill   = r_fill - CW'(1);
                n_state  = S_FIN;
            end
            S_SCAN: begin
                n_match = r_match + CW'(hit);
                if (keep) begin
                    ram_we   = 1'b1;
                    n_wr_cnt = r_wr_cnt + CW'(1);
                end
                n_idx = r_idx + AW'(1);
                if (last) begin
                    n_fill  = r_wr_cnt + CW'(keep);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_head  <= n_head;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wr_cnt <= n_wr_cnt;
        r_match  <= n_match;
        r_status <= n_status;
        r_popped <= n_popped;
        if (in_acc) begin
            r_req <= i_req_type;
            r_val <= i_value;
        end
    end

    // Counts are reported modulo their field widths.
    always_comb begin
        match_ext = 32'(r_match);
        rem_ext   = (r_match == '0) ? 32'd0 : 32'(r_match - CW'(1));
        occ_ext   = 32'(r_fill);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            o_status        <= r_status;
            o_popped_value  <= r_popped;
            o_match_count   <= match_ext[MatchW-1:0];
            o_removed_count <= rem_ext[RemW-1:0];
            o_occupancy     <= occ_ext[OccW-1:0];
        end
    end

    assign o_out_valid = r_out_valid;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count beyond queue depth");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_START)
        else $error("accepted transaction did not start the sequencer");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_wr_cnt <= CW'(r_idx))
        else $error("compaction write overtook the scan");

    a_scan_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && last) |=> r_fill <= $past(r_fill))
        else $error("repeat removal grew the queue");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_EMPTY) |-> o_occupancy == '0)
        else $error("empty status with entries held");

endmodule

`default_nettype wire

/* tb/sv/fqvd_queue_checker.sv */
// Checker for the deduplicating FIFO: predicts each result and compares it with the block.
module fqvd_queue_checker
    import fqvd_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire logic [ReqW-1:0]        i_req_type,
    input  wire logic signed [ValW-1:0] i_value,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire logic [StatW-1:0]       i_status,
    input  wire logic signed [ValW-1:0] i_popped_value,
    input  wire logic [MatchW-1:0]      i_match_count,
    input  wire logic [RemW-1:0]        i_removed_count,
    input  wire logic [OccW-1:0]        i_occupancy,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        t_status                status;
        logic signed [ValW-1:0] popped;
        logic [MatchW-1:0]      match_cnt;
        logic [RemW-1:0]        removed;
        logic [OccW-1:0]        occupancy;
    } t_queue_result;

    // Our own copy of the queue contents, head first.
    logic signed [ValW-1:0] held_values[$];
    t_queue_result          awaited_results[$];
    int                     mismatches = 0;
    int                     awaiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = awaiting;

    function automatic t_queue_result apply_request(input t_req kind,
                                                    input logic signed [ValW-1:0] val);
        t_queue_result          r;
        logic signed [ValW-1:0] kept[$];
        int                     found;
        r = '0;
        r.status = STAT_OK;
        found = 0;
        case (kind)
            REQ_PUSH: begin
                if (held_values.size() >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    held_values.push_back(val);
                end
            end
            REQ_POP: begin
                if (held_values.size() == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.popped = held_values.pop_front();
                end
            end
            REQ_DEDUP: begin
                if (held_values.size() == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    // The first copy of the value stays in place; later copies are dropped.
                    foreach (held_values[i]) begin
                        if (held_values[i] == val) found++;
                        if (held_values[i] != val || found == 1) kept.push_back(held_values[i]);
                    end
                    held_values = kept;
                    r.match_cnt = MatchW'(found);
                    r.removed = (found > 0) ? RemW'(found - 1) : '0;
                end
            end
            default: ;
        endcase
        r.occupancy = OccW'(held_values.size());
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_queue_result want;
        if (!i_rst_n) begin
            held_values.delete();
            awaited_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(apply_request(t_req'(i_req_type), i_value));
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    note_mismatch("result transaction with no request outstanding");
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", 32'(i_status), 32'(want.status));
                    compare_field("popped_value", i_popped_value, want.popped);
                    compare_field("match_count", 32'(i_match_count), 32'(want.match_cnt));
                    compare_field("removed_count", 32'(i_removed_count), 32'(want.removed));
                    compare_field("occupancy", 32'(i_occupancy), 32'(want.occupancy));
                end
            end
        end
        awaiting = awaited_results.size();
    end

endmodule

/* tb/sv/tb_fifo_queue_with_value_dedup_top.sv */
// Testbench top for the deduplicating FIFO: clock, reset, request and result traffic, verdict.
module tb_fifo_queue_with_value_dedup_top;
    import fqvd_pkg::*;

    localparam int   DEPTH         = 16;
    localparam int   RANDOM_ITEMS  = 575;
    localparam int   IDLE_LIMIT    = 3000;
    localparam int   SETTLE_CYCLES = 40;
    localparam t_req REQ_SPARE     = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   i_out_stall = 1'b0;
    logic [ReqW-1:0]        i_req_type  = REQ_PUSH;
    logic signed [ValW-1:0] i_value     = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [StatW-1:0]       o_status;
    logic signed [ValW-1:0] o_popped_value;
    logic [MatchW-1:0]      o_match_count;
    logic [RemW-1:0]        o_removed_count;
    logic [OccW-1:0]        o_occupancy;

    int fail_count;
    int pending_count;
    int idle_cycles = 0;
    bit quiet_phase = 1'b0;

    fifo_queue_with_value_dedup_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_popped_value  (o_popped_value),
        .o_match_count   (o_match_count),
        .o_removed_count (o_removed_count),
        .o_occupancy     (o_occupancy)
    );

    fqvd_queue_checker #(
        .DEPTH(DEPTH)
    ) queue_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_popped_value  (o_popped_value),
        .i_match_count   (o_match_count),
        .i_removed_count (o_removed_count),
        .i_occupancy     (o_occupancy),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly short waits with an occasional long one; none at all in a quiet phase.
    function automatic int draw_gap();
        if (quiet_phase) return 0;
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
        return $urandom_range(0, 2);
    endfunction

    function automatic logic signed [ValW-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input t_req kind, input logic signed [ValW-1:0] val);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // Result side: a fresh stall length for every result transaction.
    initial begin : result_receiver
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : request_sender
        int                     sent;
        int                     style;
        int                     seg_len;
        int                     roll;
        t_req                   kind;
        logic signed [ValW-1:0] val;
        logic signed [ValW-1:0] pool[4];

        sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Requests on an empty queue, then a full queue of one repeated value.
        send_request(REQ_POP, '0);
        send_request(REQ_DEDUP, 32'sh7fff_ffff);
        send_request(REQ_SPARE, -1);
        repeat (DEPTH) send_request(REQ_PUSH, 32'sh8000_0000);
        send_request(REQ_PUSH, 32'sh7fff_ffff);
        send_request(REQ_DEDUP, 32'sh8000_0000);
        send_request(REQ_PUSH, 32'sh7fff_ffff);
        send_request(REQ_PUSH, -1);
        send_request(REQ_DEDUP, -1);
        send_request(REQ_DEDUP, 32'sh0000_3039);
        send_request(REQ_POP, '0);
        wait_for_results();

        // Segments lean towards filling, draining or deduplicating, with values
        // drawn mostly from a small pool so that repeats are common.
        while (sent < RANDOM_ITEMS) begin
            style       = $urandom_range(0, 2);
            seg_len     = $urandom_range(10, 40);
            quiet_phase = ($urandom_range(0, 4) == 0);
            foreach (pool[k]) pool[k] = pick_value();
            for (int n = 0; n < seg_len; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    kind = REQ_SPARE;
                else if (roll < ((style == 0) ? 70 : (style == 1) ? 35 : 55))
                    kind = REQ_PUSH;
                else if (roll < ((style == 0) ? 85 : (style == 1) ? 78 : 65))
                    kind = REQ_POP;
                else
                    kind = REQ_DEDUP;
                val = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 3)];
                send_request(kind, val);
                if (kind != REQ_SPARE) sent++;
            end
            if ($urandom_range(0, 3) == 0) wait_for_results();
        end
        quiet_phase = 1'b0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
